>>> rtl/core/spcp_pkg.sv
package spcp_pkg;

   localparam int FRAME_LENGTH = 16;
   localparam int POS_W        = $clog2(FRAME_LENGTH);
   localparam int LAST_SCAN    = 9;

   localparam int PIN_W  = 7;
   localparam int VAL_W  = 14;
   localparam int MASK_W = 12;
   localparam int DUTY_W = 8;

   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [PIN_W-1:0] PIN_LOW  = 7'd2;
   localparam logic [PIN_W-1:0] PIN_HIGH = 7'd13;
   localparam logic [VAL_W-1:0] DUTY_MAX = 14'd255;

   localparam logic [POS_W-1:0] OFF_PIN_HI = POS_W'(1);
   localparam logic [POS_W-1:0] OFF_PIN_LO = POS_W'(2);
   localparam logic [POS_W-1:0] OFF_CMD    = POS_W'(3);
   localparam logic [POS_W-1:0] OFF_VAL_HI = POS_W'(4);
   localparam logic [POS_W-1:0] OFF_VAL_LO = POS_W'(7);

   typedef enum logic [1:0] {
      KIND_DIGITAL = 2'd0,
      KIND_PWM     = 2'd1,
      KIND_OTHER   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [PIN_W-1:0] pin;
      kind_type         kind;
      logic [VAL_W-1:0] val;
      logic             bad;
   } job_type;

endpackage

>>> rtl/core/spcp_front.sv
module spcp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               push,
   output spcp_pkg::job_type  push_job,
   input  logic               queue_full
);
   import spcp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic             seen_ff, seen_in;
   logic             found_ff, found_in;
   logic [PIN_W-1:0] pin_ff, pin_in;
   logic [VAL_W-1:0] val_ff, val_in;
   kind_type         kind_ff, kind_in;
   logic             bad_ff, bad_in;

   logic             accept;
   logic             last;
   logic             is_digit;
   logic [3:0]       digit;
   logic [POS_W-1:0] off;

   assign last      = (pos_ff == POS_W'(FRAME_LENGTH - 1));
   assign req_ready = !(last && queue_full);
   assign accept    = req_valid && req_ready;

   assign is_digit = req_rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
   assign digit    = is_digit ? 4'(req_rx_byte - CHAR_ZERO) : 4'd0;
   assign off      = pos_ff - start_ff;

   always_comb begin
      start_in = start_ff;
      seen_in  = seen_ff;
      found_in = found_ff;
      pin_in   = pin_ff;
      val_in   = val_ff;
      kind_in  = kind_ff;
      bad_in   = bad_ff;
      if (!seen_ff && req_rx_byte == CHAR_P) begin
         seen_in = 1'b1;
         if (pos_ff < POS_W'(LAST_SCAN)) begin
            found_in = 1'b1;
            start_in = pos_ff;
         end
      end
      if (found_ff) begin
         if (off == OFF_PIN_HI || off == OFF_PIN_LO) begin
            pin_in = PIN_W'(pin_ff * PIN_W'(10) + PIN_W'(digit));
            bad_in = bad_ff || !is_digit;
         end else if (off == OFF_CMD) begin
            if (req_rx_byte == CHAR_B) begin
               kind_in = KIND_DIGITAL;
            end else if (req_rx_byte == CHAR_R) begin
               kind_in = KIND_PWM;
            end else begin
               kind_in = KIND_OTHER;
            end
         end else if (off >= OFF_VAL_HI && off <= OFF_VAL_LO) begin
            val_in = VAL_W'(val_ff * VAL_W'(10) + VAL_W'(digit));
            bad_in = bad_ff || !is_digit;
         end
      end
   end

   assign push          = accept && last && found_ff;
   assign push_job.pin  = pin_in;
   assign push_job.kind = kind_in;
   assign push_job.val  = val_in;
   assign push_job.bad  = bad_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         seen_ff  <= 1'b0;
         found_ff <= 1'b0;
         pin_ff   <= '0;
         val_ff   <= '0;
         bad_ff   <= 1'b0;
         start_ff <= '0;
         kind_ff  <= KIND_OTHER;
      end else if (accept) begin
         if (last) begin
            pos_ff   <= '0;
            seen_ff  <= 1'b0;
            found_ff <= 1'b0;
            pin_ff   <= '0;
            val_ff   <= '0;
            bad_ff   <= 1'b0;
         end else begin
            pos_ff   <= pos_ff + POS_W'(1);
            seen_ff  <= seen_in;
            found_ff <= found_in;
            pin_ff   <= pin_in;
            val_ff   <= val_in;
            bad_ff   <= bad_in;
            start_ff <= start_in;
            kind_ff  <= kind_in;
         end
      end
   end

endmodule

>>> rtl/core/spcp_queue.sv
module spcp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  spcp_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output spcp_pkg::job_type  head
);
   import spcp_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head      = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   assign wr_in    = do_push ? !wr_ff : wr_ff;
   assign rd_in    = do_pop ? !rd_ff : rd_ff;
   assign count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/spcp_back.sv
module spcp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [spcp_pkg::MASK_W-1:0] invert_mask,
   input  logic                        job_valid,
   input  spcp_pkg::job_type           job,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [6:0]                  rsp_pin_number,
   output logic [1:0]                  rsp_command_kind,
   output logic [13:0]                 rsp_raw_value,
   output logic                        rsp_drive_level,
   output logic [7:0]                  rsp_drive_duty,
   output logic                        rsp_pin_in_range,
   output logic                        rsp_malformed
);
   import spcp_pkg::*;

   logic              valid_ff;
   logic [PIN_W-1:0]  pin_ff;
   kind_type          kind_ff;
   logic [VAL_W-1:0]  val_ff;
   logic              level_ff, level_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic              range_ff, range_in;
   logic              bad_ff;

   logic       inv;
   logic       over;
   logic [3:0] bit_idx;
   logic [MASK_W-1:0] shifted;

   assign range_in = (job.pin >= PIN_LOW) && (job.pin <= PIN_HIGH);
   assign bit_idx  = 4'(job.pin) - 4'd2;
   assign shifted  = invert_mask >> bit_idx;
   assign inv      = range_in && shifted[0];
   assign over     = (job.val > DUTY_MAX);

   always_comb begin
      level_in = 1'b0;
      duty_in  = '0;
      case (job.kind)
         KIND_DIGITAL: begin
            level_in = (job.val != '0) ^ inv;
         end
         KIND_PWM: begin
            if (over) begin
               duty_in = inv ? '0 : '1;
            end else begin
               duty_in = inv ? ~job.val[DUTY_W-1:0] : job.val[DUTY_W-1:0];
            end
         end
         default: begin
            level_in = 1'b0;
         end
      endcase
   end

   assign pop = job_valid && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pin_ff   <= job.pin;
         kind_ff  <= job.kind;
         val_ff   <= job.val;
         level_ff <= level_in;
         duty_ff  <= duty_in;
         range_ff <= range_in;
         bad_ff   <= job.bad;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pin_number   = pin_ff;
   assign rsp_command_kind = kind_ff;
   assign rsp_raw_value    = val_ff;
   assign rsp_drive_level  = level_ff;
   assign rsp_drive_duty   = duty_ff;
   assign rsp_pin_in_range = range_ff;
   assign rsp_malformed    = bad_ff;

endmodule

>>> rtl/core/serial_pin_command_parser_core.sv
// Channel   Direction  Handshake           Payload
// req       in         req_valid/ready     req_rx_byte
// rsp       out        rsp_valid/ready     pin, kind, value, level, duty, range, malformed
// csr       in         csr_we (no wait)    csr_wdata = invert mask
//
// One byte accepted per cycle while req_ready is high; the frame is parsed as it
// streams in, so a command enters the job queue at the edge that takes its sixteenth
// byte and from there moves into the output register whenever that register is free.
// A two-entry job queue separates front and back;
// req_ready drops only on a frame's last byte while that queue is full.
// Synchronous reset clears the frame position, queue and output valid.
module serial_pin_command_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_pin_number,
   output logic [1:0]  rsp_command_kind,
   output logic [13:0] rsp_raw_value,
   output logic        rsp_drive_level,
   output logic [7:0]  rsp_drive_duty,
   output logic        rsp_pin_in_range,
   output logic        rsp_malformed,
   input  logic        csr_we,
   input  logic [11:0] csr_wdata
);
   import spcp_pkg::*;

   logic [MASK_W-1:0] mask_ff;
   logic              push;
   job_type           push_job;
   logic              queue_full;
   logic              pop;
   logic              not_empty;
   job_type           head;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_we) begin
         mask_ff <= csr_wdata;
      end
   end

   spcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .push        (push),
      .push_job    (push_job),
      .queue_full  (queue_full)
   );

   spcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   spcp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .invert_mask      (mask_ff),
      .job_valid        (not_empty),
      .job              (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pin_number   (rsp_pin_number),
      .rsp_command_kind (rsp_command_kind),
      .rsp_raw_value    (rsp_raw_value),
      .rsp_drive_level  (rsp_drive_level),
      .rsp_drive_duty   (rsp_drive_duty),
      .rsp_pin_in_range (rsp_pin_in_range),
      .rsp_malformed    (rsp_malformed)
   );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import spcp_pkg::*;

   localparam logic [7:0] SLASH = 8'h2F;
   localparam int SCAN_LIMIT = 9;
   localparam int FRAMES_PER_PHASE = 14;

   typedef struct {
      logic [PIN_W-1:0]  pin;
      kind_type          kind;
      logic [VAL_W-1:0]  value;
      logic              level;
      logic [DUTY_W-1:0] duty;
      logic              in_range;
      logic              malformed;
   } pin_command_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_pin_number;
   logic [1:0]  rsp_command_kind;
   logic [13:0] rsp_raw_value;
   logic        rsp_drive_level;
   logic [7:0]  rsp_drive_duty;
   logic        rsp_pin_in_range;
   logic        rsp_malformed;
   logic        csr_we = 1'b0;
   logic [11:0] csr_wdata = 12'h000;

   logic [7:0]        pending_bytes[$];
   pin_command_type   expected_commands[$];
   logic [7:0]        frame_bytes[FRAME_LENGTH];
   int                frame_fill = 0;
   logic [MASK_W-1:0] mask_model = '0;
   int                error_count = 0;

   bit req_fire = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   bit hold_request = 1'b0;
   bit hold_served = 1'b0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   serial_pin_command_parser_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pin_number(rsp_pin_number),
      .rsp_command_kind(rsp_command_kind),
      .rsp_raw_value(rsp_raw_value),
      .rsp_drive_level(rsp_drive_level),
      .rsp_drive_duty(rsp_drive_duty),
      .rsp_pin_in_range(rsp_pin_in_range),
      .rsp_malformed(rsp_malformed),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int frame_digit(input int pos, inout bit bad);
      logic [7:0] c;
      c = frame_bytes[pos];
      if (c < CHAR_ZERO || c > CHAR_NINE) begin
         bad = 1'b1;
         return 0;
      end
      return int'(c - CHAR_ZERO);
   endfunction

   // Stores one byte; on a full frame, decodes the command and clears the frame.
   task automatic take_byte(input logic [7:0] b);
      int start;
      int pin;
      int val;
      bit bad;
      bit inv;
      logic [7:0] cmd;
      pin_command_type r;
      frame_bytes[frame_fill] = b;
      frame_fill++;
      if (frame_fill != FRAME_LENGTH) return;
      frame_fill = 0;
      start = -1;
      for (int i = 0; i < FRAME_LENGTH; i++) begin
         if (frame_bytes[i] == CHAR_P) begin
            start = i;
            break;
         end
      end
      if (start >= 0 && start < SCAN_LIMIT) begin
         bad = 1'b0;
         pin = frame_digit(start + 1, bad) * 10 + frame_digit(start + 2, bad);
         cmd = frame_bytes[start + 3];
         val = frame_digit(start + 4, bad) * 1000 + frame_digit(start + 5, bad) * 100
             + frame_digit(start + 6, bad) * 10 + frame_digit(start + 7, bad);
         r.pin = PIN_W'(pin);
         r.value = VAL_W'(val);
         r.in_range = (pin >= int'(PIN_LOW) && pin <= int'(PIN_HIGH));
         inv = r.in_range && mask_model[pin - int'(PIN_LOW)];
         r.level = 1'b0;
         r.duty = '0;
         if (cmd == CHAR_B) begin
            r.kind = KIND_DIGITAL;
            r.level = (val != 0) ^ inv;
         end else if (cmd == CHAR_R) begin
            r.kind = KIND_PWM;
            if (inv)
               r.duty = DUTY_W'((val > int'(DUTY_MAX)) ? 0 : int'(DUTY_MAX) - val);
            else
               r.duty = DUTY_W'((val > int'(DUTY_MAX)) ? int'(DUTY_MAX) : val);
         end else begin
            r.kind = KIND_OTHER;
         end
         r.malformed = bad;
         expected_commands.push_back(r);
      end
      foreach (frame_bytes[i]) frame_bytes[i] = SLASH;
   endtask

   task automatic check_result();
      pin_command_type want;
      if (expected_commands.size() == 0) begin
         report_mismatch("result with none pending, pin", rsp_pin_number, 0);
         return;
      end
      want = expected_commands.pop_front();
      if (rsp_pin_number !== want.pin)
         report_mismatch("pin_number", rsp_pin_number, want.pin);
      if (rsp_command_kind !== want.kind)
         report_mismatch("command_kind", rsp_command_kind, want.kind);
      if (rsp_raw_value !== want.value)
         report_mismatch("raw_value", rsp_raw_value, want.value);
      if (rsp_drive_level !== want.level)
         report_mismatch("drive_level", rsp_drive_level, want.level);
      if (rsp_drive_duty !== want.duty)
         report_mismatch("drive_duty", rsp_drive_duty, want.duty);
      if (rsp_pin_in_range !== want.in_range)
         report_mismatch("pin_in_range", rsp_pin_in_range, want.in_range);
      if (rsp_malformed !== want.malformed)
         report_mismatch("malformed", rsp_malformed, want.malformed);
   endtask

   always @(posedge clock) begin
      req_fire = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready === 1'b1) begin
            req_fire = 1'b1;
            take_byte(req_rx_byte);
         end
         if (rsp_valid === 1'b1 && rsp_ready) check_result();
      end
   end

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(0, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern changes mode now and then, plus long hold-offs.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            hold_left = 400;
         end else if (hold_left == 0 && $urandom_range(0, 2999) == 0) begin
            hold_left = $urandom_range(60, 250);
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(30, 200);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_ready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
   endtask

   task automatic queue_frame(input string s);
      for (int i = 0; i < FRAME_LENGTH; i++)
         pending_bytes.push_back((i < s.len()) ? s[i] : SLASH);
   endtask

   function automatic logic [7:0] random_not_p();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_P);
      return b;
   endfunction

   task automatic queue_random_frame();
      int start;
      int pin;
      int val;
      int k;
      logic [7:0] body[8];
      start = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      pin = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(2, 13);
      case ($urandom_range(0, 7))
         0: val = 0;
         1, 2, 3: val = $urandom_range(0, 300);
         default: val = $urandom_range(0, 9999);
      endcase
      body[0] = CHAR_P;
      body[1] = CHAR_ZERO + 8'(pin / 10);
      body[2] = CHAR_ZERO + 8'(pin % 10);
      case ($urandom_range(0, 4))
         0, 1: body[3] = CHAR_B;
         2, 3: body[3] = CHAR_R;
         default: body[3] = 8'($urandom_range(0, 255));
      endcase
      body[4] = CHAR_ZERO + 8'(val / 1000);
      body[5] = CHAR_ZERO + 8'((val / 100) % 10);
      body[6] = CHAR_ZERO + 8'((val / 10) % 10);
      body[7] = CHAR_ZERO + 8'(val % 10);
      if ($urandom_range(0, 7) == 0) begin
         k = $urandom_range(0, 5);
         body[(k < 2) ? k + 1 : k + 2] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < FRAME_LENGTH; i++) begin
         if (i < start) pending_bytes.push_back(random_not_p());
         else if (i - start < 8) pending_bytes.push_back(body[i - start]);
         else pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
      // stray bytes knock the framing out of step
      if ($urandom_range(0, 9) == 0) begin
         k = $urandom_range(1, 3);
         repeat (k) pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic write_mask(input logic [MASK_W-1:0] m);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
      mask_model = m;
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [MASK_W-1:0] phase_masks[5];
      foreach (frame_bytes[i]) frame_bytes[i] = SLASH;
      phase_masks[0] = 12'h000;
      phase_masks[1] = 12'hFFF;
      phase_masks[2] = 12'h555;
      phase_masks[3] = 12'hAAA;
      phase_masks[4] = MASK_W'($urandom_range(0, 4095));
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // pins 2 and 13 inverted
      write_mask(12'h801);
      queue_frame("P02B0001");
      queue_frame("P13R0100");
      queue_frame("P03B0000");
      queue_frame("P12R9999");
      queue_frame("P13R0300");
      queue_frame("P13R0255");
      queue_frame("P00R0000");
      queue_frame("////////P99X9999");
      queue_frame("/////////P01B000");
      queue_frame("");
      queue_frame("P0aB12z4");
      queue_frame("PP12B0001");
      queue_frame("P14B0000");
      queue_frame("P09b0001");
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      queue_text("P05R0042");
      repeat (6) pending_bytes.push_back(8'hFF);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_mask(phase_masks[p]);
         for (int n = 0; n < FRAMES_PER_PHASE; n++) queue_random_frame();
         if (p == 0) hold_request = 1'b1;
         drain();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/spcp_pkg.sv
rtl/core/spcp_front.sv
rtl/core/spcp_queue.sv
rtl/core/spcp_back.sv
rtl/core/serial_pin_command_parser_core.sv
test/testbench.sv
